@@ rtl/core/pjd_pkg.sv @@
// shared types and constants for the periodic job dispatcher
`default_nettype none
package pjd_pkg;

  localparam int MAX_JOBS        = 16;
  localparam int PRIORITY_LEVELS = 4;
  localparam int SLOT_W          = $clog2(MAX_JOBS);
  localparam int LVL_W           = $clog2(PRIORITY_LEVELS);
  localparam int POS_W           = SLOT_W + LVL_W;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ACT_REGISTER   = 3'd0,
    ACT_DEREGISTER = 3'd1,
    ACT_REQUEUE    = 3'd2,
    ACT_SET_IVL    = 3'd3,
    ACT_DISPATCH   = 3'd4,
    ACT_COMPLETE   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  job_slot;
    logic [1:0]  new_priority;
    logic [31:0] new_interval;
    logic [31:0] now_ms;
    logic        remove_job;
    logic        change_priority;
    logic        change_interval;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  result_slot;
    logic        job_due;
    logic [31:0] overshoot_ms;
    logic [31:0] next_due_ms;
  } out_t;

  typedef struct packed {
    logic [1:0]  priority_lvl;
    logic [31:0] interval;
    logic [31:0] last_run;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        due;
    logic [31:0] overshoot;
    logic [31:0] wait_ms;
  } eval_t;

endpackage
`default_nettype wire

@@ rtl/core/pjd_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module pjd_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pjd_eval.sv @@
// due test, overshoot and time-to-due for one table entry
`default_nettype none
module pjd_eval
  import pjd_pkg::*;
(
  input  wire logic [31:0] last_run,
  input  wire logic [31:0] interval,
  input  wire logic [31:0] now_ms,
  output eval_t            ev
);

  logic [31:0] elapsed;

  assign elapsed      = now_ms - last_run;
  assign ev.due       = elapsed >= interval;
  assign ev.overshoot = elapsed - interval;
  assign ev.wait_ms   = last_run + interval - now_ms;

endmodule
`default_nettype wire

@@ rtl/core/periodic_job_dispatcher.sv @@
// top level: job table control, dispatch scan and result register
`default_nettype none
// One transaction in, one result out. Requeue, set interval and complete
// (unless it removes the job) do one read-modify-write of the job memory.
// Dispatch walks the table one position per cycle when the slot is empty;
// an occupied slot takes a memory read, then an evaluate. A dispatch covers
// up to two passes of 64 positions. A new transaction is taken as soon as
// the result is in the output register, even if it has not been taken yet.
module periodic_job_dispatcher
  import pjd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  state_t state_r, state_nxt;
  in_t    req_r, req_nxt;
  out_t   res_r, res_nxt, out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [MAX_JOBS-1:0] valid_r, valid_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic   second_r, second_nxt;
  logic   pass_ran_r, pass_ran_nxt;
  logic [31:0] least_r, least_nxt;
  logic [SLOT_W-1:0] pending_r, pending_nxt;
  logic   awaiting_r, awaiting_nxt;

  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] k;
  logic [LVL_W-1:0]  lvl;
  logic              lvl_match, pos_last, rerun, out_load;
  logic [31:0]       least_upd, ev_ivl;
  eval_t             ev;

  assign rd        = entry_t'(ram_rdata);
  assign k         = pos_r[SLOT_W-1:0];
  assign lvl       = pos_r[POS_W-1:SLOT_W];
  assign lvl_match = rd.priority_lvl == lvl;
  assign pos_last  = &pos_r;
  assign rerun     = pass_ran_r && !second_r;
  assign out_load  = !out_valid_r || out_ready;
  assign ev_ivl    = (req_r.action == ACT_SET_IVL) ? req_r.new_interval : rd.interval;

  pjd_ram #(.DW(ENTRY_W), .AW(SLOT_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pjd_eval u_eval (
    .last_run (rd.last_run),
    .interval (ev_ivl),
    .now_ms   (req_r.now_ms),
    .ev       (ev)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    least_upd = least_r;
    if (state_r == ST_SCAN_EV && lvl_match && ev.wait_ms < least_r) begin
      least_upd = ev.wait_ms;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_RESP;
        case (req_r.action)
          ACT_REQUEUE, ACT_SET_IVL: begin
            if (valid_r[req_r.job_slot]) state_nxt = ST_MOD;
          end
          ACT_DISPATCH: begin
            if (!awaiting_r) state_nxt = ST_SCAN_RD;
          end
          ACT_COMPLETE: begin
            if (awaiting_r && valid_r[pending_r] && !req_r.remove_job) state_nxt = ST_MOD;
          end
          default: state_nxt = ST_RESP;
        endcase
      end
      ST_MOD: state_nxt = ST_RESP;
      ST_SCAN_RD: begin
        if (valid_r[k]) begin
          state_nxt = ST_SCAN_EV;
        end else if (pos_last && !rerun) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCAN_EV: begin
        if ((lvl_match && ev.due) || (pos_last && !rerun)) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt      = req_r;
    res_nxt      = res_r;
    valid_nxt    = valid_r;
    pos_nxt      = pos_r;
    second_nxt   = second_r;
    pass_ran_nxt = pass_ran_r;
    least_nxt    = least_r;
    pending_nxt  = pending_r;
    awaiting_nxt = awaiting_r;
    out_nxt      = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = rd;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) req_nxt = in_data;
      end
      ST_DECODE: begin
        res_nxt = '0;
        case (req_r.action)
          ACT_REGISTER: begin
            if (free_found) begin
              valid_nxt[free_idx]    = 1'b1;
              ram_we                 = 1'b1;
              ram_waddr              = free_idx;
              ram_wdata.priority_lvl = req_r.new_priority;
              ram_wdata.interval     = req_r.new_interval;
              ram_wdata.last_run     = req_r.now_ms;
              res_nxt.ok             = 1'b1;
              res_nxt.result_slot    = free_idx;
            end
          end
          ACT_DEREGISTER: begin
            if (valid_r[req_r.job_slot]) begin
              valid_nxt[req_r.job_slot] = 1'b0;
              res_nxt.ok = 1'b1;
            end
          end
          ACT_REQUEUE, ACT_SET_IVL: begin
            if (valid_r[req_r.job_slot]) begin
              ram_re     = 1'b1;
              ram_raddr  = req_r.job_slot;
              res_nxt.ok = 1'b1;
            end
          end
          ACT_DISPATCH: begin
            second_nxt = 1'b0;
          end
          ACT_COMPLETE: begin
            if (awaiting_r) begin
              awaiting_nxt = 1'b0;
              res_nxt.ok   = 1'b1;
              if (valid_r[pending_r]) begin
                if (req_r.remove_job) begin
                  valid_nxt[pending_r] = 1'b0;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = pending_r;
                end
              end
            end
          end
          default: res_nxt = '0;
        endcase
      end
      ST_MOD: begin
        ram_we = 1'b1;
        case (req_r.action)
          ACT_REQUEUE: begin
            ram_waddr          = req_r.job_slot;
            ram_wdata.last_run = req_r.now_ms;
          end
          ACT_SET_IVL: begin
            ram_waddr          = req_r.job_slot;
            ram_wdata.interval = req_r.new_interval;
            if (ev.wait_ms < least_r) least_nxt = ev.wait_ms;
          end
          default: begin
            ram_waddr          = pending_r;
            ram_wdata.last_run = rd.last_run + rd.interval;
            if (req_r.change_priority) ram_wdata.priority_lvl = req_r.new_priority;
            if (req_r.change_interval) ram_wdata.interval = req_r.new_interval;
          end
        endcase
      end
      ST_SCAN_RD, ST_SCAN_EV: begin
        if (state_r == ST_SCAN_RD && valid_r[k]) begin
          ram_re    = 1'b1;
          ram_raddr = k;
        end else if (state_r == ST_SCAN_EV && lvl_match && ev.due) begin
          pending_nxt         = k;
          awaiting_nxt        = 1'b1;
          res_nxt.ok          = 1'b1;
          res_nxt.result_slot = k;
          res_nxt.job_due     = 1'b1;
          res_nxt.overshoot_ms = ev.overshoot;
          if (pos_last) begin
            pass_ran_nxt = 1'b0;
            least_nxt    = ALL_ONES;
            pos_nxt      = '0;
          end else begin
            pass_ran_nxt = 1'b1;
            pos_nxt      = pos_r + 1'b1;
          end
        end else if (!pos_last) begin
          least_nxt = least_upd;
          pos_nxt   = pos_r + 1'b1;
        end else if (rerun) begin
          // a job ran this pass: start a fresh pass from the top
          second_nxt   = 1'b1;
          pass_ran_nxt = 1'b0;
          least_nxt    = ALL_ONES;
          pos_nxt      = '0;
        end else begin
          res_nxt.ok          = 1'b1;
          res_nxt.next_due_ms = least_upd;
          pass_ran_nxt        = 1'b0;
          least_nxt           = ALL_ONES;
          pos_nxt             = '0;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      pos_r       <= '0;
      second_r    <= 1'b0;
      pass_ran_r  <= 1'b0;
      least_r     <= ALL_ONES;
      pending_r   <= '0;
      awaiting_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      pos_r       <= pos_nxt;
      second_r    <= second_nxt;
      pass_ran_r  <= pass_ran_nxt;
      least_r     <= least_nxt;
      pending_r   <= pending_nxt;
      awaiting_r  <= awaiting_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_due_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.job_due |-> out_data.ok)
    else $error("dispatched transaction without ok");

  a_await_from_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(awaiting_r) |-> res_r.job_due && state_r == ST_RESP)
    else $error("completion pending without a dispatched job");

  a_no_scan_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_RD || state_r == ST_SCAN_EV) |-> !awaiting_r)
    else $error("scan running while a completion is pending");
`endif

endmodule
`default_nettype wire

@@ dv/periodic_job_dispatcher_test.sv @@
// self-checking testbench for the periodic job dispatcher
`default_nettype none
module periodic_job_dispatcher_test;
  import pjd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCAN_TOTAL = MAX_JOBS * PRIORITY_LEVELS;
  localparam int IDLE_LIMIT = 5000;

  // job table model with expected-result queue
  class job_table_scoreboard;
    bit          valid_q[MAX_JOBS];
    logic [1:0]  prio_q[MAX_JOBS];
    logic [31:0] ivl_q[MAX_JOBS];
    logic [31:0] last_q[MAX_JOBS];
    int unsigned cursor;
    bit          ran;
    logic [31:0] least;
    logic [3:0]  pending;
    bit          waiting;
    out_t        expected_q[$];
    int          mismatches;

    function void clear();
      foreach (valid_q[i]) valid_q[i] = 0;
      pending = 0;
      waiting = 0;
      restart();
    endfunction

    function void restart();
      ran = 0;
      least = ALL_ONES;
      cursor = 0;
    endfunction

    function void note_transaction(in_t t);
      out_t r;
      logic [31:0] el, w;
      int unsigned pos, lvl, k;
      bit done;
      bit slot_ok;
      r = '0;
      slot_ok = valid_q[t.job_slot];
      case (t.action)
        ACT_REGISTER: begin
          for (int i = 0; i < MAX_JOBS; i++) begin
            if (!valid_q[i]) begin
              valid_q[i] = 1;
              prio_q[i] = t.new_priority;
              ivl_q[i] = t.new_interval;
              last_q[i] = t.now_ms;
              r.ok = 1;
              r.result_slot = i[3:0];
              break;
            end
          end
        end
        ACT_DEREGISTER: if (slot_ok) begin
          valid_q[t.job_slot] = 0;
          r.ok = 1;
        end
        ACT_REQUEUE: if (slot_ok) begin
          last_q[t.job_slot] = t.now_ms;
          r.ok = 1;
        end
        ACT_SET_IVL: if (slot_ok) begin
          ivl_q[t.job_slot] = t.new_interval;
          w = last_q[t.job_slot] + t.new_interval - t.now_ms;
          if (w < least) least = w;
          r.ok = 1;
        end
        ACT_DISPATCH: if (!waiting) begin
          pos = cursor;
          done = 0;
          for (int round = 0; round < 3 && !done; round++) begin
            for (; pos < SCAN_TOTAL; pos++) begin
              lvl = pos / MAX_JOBS;
              k = pos % MAX_JOBS;
              if (!valid_q[k] || prio_q[k] != lvl) continue;
              el = t.now_ms - last_q[k];
              if (el >= ivl_q[k]) begin
                pending = k[3:0];
                waiting = 1;
                ran = 1;
                r.ok = 1;
                r.result_slot = k[3:0];
                r.job_due = 1;
                r.overshoot_ms = el - ivl_q[k];
                if (pos + 1 >= SCAN_TOTAL) restart();
                else cursor = pos + 1;
                done = 1;
                break;
              end else begin
                w = last_q[k] + ivl_q[k] - t.now_ms;
                if (w < least) least = w;
              end
            end
            if (done) break;
            if (ran && round < 2) begin
              restart();
              pos = 0;
            end else begin
              r.ok = 1;
              r.next_due_ms = least;
              restart();
              done = 1;
            end
          end
        end
        ACT_COMPLETE: if (waiting) begin
          waiting = 0;
          r.ok = 1;
          if (valid_q[pending]) begin
            if (t.remove_job) valid_q[pending] = 0;
            else begin
              last_q[pending] += ivl_q[pending];
              if (t.change_priority) prio_q[pending] = t.new_priority;
              if (t.change_interval) ivl_q[pending] = t.new_interval;
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        report(got, got, "unexpected result");
        return;
      end
      e = expected_q.pop_front();
      if (got.ok !== e.ok || got.result_slot !== e.result_slot ||
          got.job_due !== e.job_due || got.overshoot_ms !== e.overshoot_ms ||
          got.next_due_ms !== e.next_due_ms)
        report(e, got, "result mismatch");
    endfunction

    function void report(out_t e, out_t got, string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: exp ok=%0b slot=%0d due=%0b over=%h next=%h",
                 what, e.ok, e.result_slot, e.job_due, e.overshoot_ms, e.next_due_ms);
        $display("  got ok=%0b slot=%0d due=%0b over=%h next=%h",
                 got.ok, got.result_slot, got.job_due, got.overshoot_ms, got.next_due_ms);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;

  job_table_scoreboard sb;
  logic [31:0] clock_ms = 0;
  bit stall_en = 1;
  int idle_cycles = 0;

  periodic_job_dispatcher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver stall pattern: rotating mask with occasional all-ready phases
  logic [15:0] stall_mask = 16'hb4c3;
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 400 == 0) stall_mask <= 16'($urandom);
    out_ready <= !stall_en || (stall_phase % 400 > 300) || stall_mask[stall_phase % 16];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_transaction(in_t t);
    in_valid <= 1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(t);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic in_t make_item(action_t a, logic [3:0] slot, logic [1:0] prio,
                                    logic [31:0] ivl, logic [31:0] now);
    in_t t;
    t = '0;
    t.action = a;
    t.job_slot = slot;
    t.new_priority = prio;
    t.new_interval = ivl;
    t.now_ms = now;
    return t;
  endfunction

  function automatic in_t random_item();
    in_t t;
    int pick;
    t = '0;
    t.new_interval = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 60);
    t.now_ms = clock_ms;
    t.job_slot = 4'($urandom);
    t.new_priority = 2'($urandom);
    t.change_priority = 1'($urandom);
    t.change_interval = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) t.action = ACT_REGISTER;
    else if (pick < 22) t.action = ACT_DEREGISTER;
    else if (pick < 30) t.action = ACT_REQUEUE;
    else if (pick < 37) t.action = ACT_SET_IVL;
    else if (pick < 70) t.action = ACT_DISPATCH;
    else if (pick < 97) t.action = ACT_COMPLETE;
    else t.action = action_t'($urandom_range(6, 7));
    t.remove_job = ($urandom_range(0, 5) == 0);
    return t;
  endfunction

  initial begin
    in_t t;
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, extremes, full table, odd sequences
    send_transaction(make_item(ACT_DISPATCH, 0, 0, 0, 0));
    send_transaction(make_item(ACT_COMPLETE, 0, 0, 0, 0));
    send_transaction(make_item(ACT_DEREGISTER, 4'hf, 0, 0, 0));
    send_transaction(make_item(ACT_REQUEUE, 3, 0, 0, 0));
    send_transaction(make_item(ACT_SET_IVL, 7, 0, 1, 0));
    for (int i = 0; i < MAX_JOBS + 1; i++)
      send_transaction(make_item(ACT_REGISTER, 0, i[1:0], (i == 0) ? ALL_ONES : i * 5,
                                 (i == 1) ? ALL_ONES : 32'd0));
    send_transaction(make_item(ACT_SET_IVL, 2, 0, ALL_ONES, ALL_ONES));
    send_transaction(make_item(ACT_DISPATCH, 0, 0, 0, 32'd100));
    send_transaction(make_item(ACT_DISPATCH, 0, 0, 0, 32'd100));
    t = make_item(ACT_COMPLETE, 0, 2'd3, ALL_ONES, 0);
    t.change_priority = 1;
    t.change_interval = 1;
    send_transaction(t);

    for (int n = 0; n < 850; n++) begin
      if (n % 200 == 100) stall_en = !stall_en;
      if ($urandom_range(0, 1)) clock_ms += $urandom_range(0, 20);
      if ($urandom_range(0, 200) == 0) clock_ms = $urandom;
      send_transaction(random_item());
      if ($urandom_range(0, 7) == 0) random_gap();
    end

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
